### hdl/sdc_pkg.sv
// Shared types, constants and calendar helpers of the serial date converter.
`timescale 1ns / 1ps
`default_nettype none
package sdc_pkg;

  localparam int unsigned BASE_YEAR    = 1900;
  localparam int unsigned FIRST_SERIAL = 61;
  localparam int unsigned LEAPS_TO_1899 = 1899 / 4 - 1899 / 100 + 1899 / 400;
  // Remainders of the base year, used to seed the year-walk counters.
  localparam int unsigned BASE_MOD400 = BASE_YEAR % 400;
  localparam int unsigned BASE_MOD100 = BASE_YEAR % 100;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_DATE = 2'd1;
  localparam status_t ST_RANGE    = 2'd2;

  localparam logic CMD_DATE_TO_SERIAL = 1'b0;
  localparam logic CMD_SERIAL_TO_DATE = 1'b1;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef logic [4:0] mlen_t;
  localparam mlen_t MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                       5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic year_step;
    logic month_step;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic bad;
    logic year_done;
    logic month_done;
  } dp_stat_t;

  // Length of a month 1..12; month codes outside that range give zero.
  function automatic mlen_t days_in_month(input logic [3:0] month, input logic leap);
    mlen_t len;
    len = 5'd0;
    if (month != 4'd0 && month <= MONTH_DEC) begin
      len = MONTH_LEN[month - 4'd1];
      if (month == MONTH_FEB && leap) begin
        len = 5'd29;
      end
    end
    return len;
  endfunction

endpackage
`default_nettype wire

### hdl/sdc_in_if.sv
// Input channel of the serial date converter: handshake and request payload.
`timescale 1ns / 1ps
`default_nettype none
interface sdc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [11:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [16:0] in_serial;

  modport source (output valid, cmd, in_year, in_month, in_day, in_serial, input ready);
  modport sink   (input valid, cmd, in_year, in_month, in_day, in_serial, output ready);
endinterface
`default_nettype wire

### hdl/sdc_out_if.sv
// Result channel of the serial date converter: handshake and result payload.
`timescale 1ns / 1ps
`default_nettype none
interface sdc_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] out_serial;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [1:0]  status;

  modport source (output valid, out_serial, out_year, out_month, out_day, status,
                  input ready);
  modport sink   (input valid, out_serial, out_year, out_month, out_day, status,
                  output ready);
endinterface
`default_nettype wire

### hdl/sdc_datapath.sv
// Datapath of the serial date converter: operand, walk and result registers.
`timescale 1ns / 1ps
`default_nettype none
module sdc_datapath #(
  parameter int unsigned YEAR_SPAN = 256
) (
  input  wire logic              clk,
  input  wire sdc_pkg::ctrl_cmd_t ctrl,
  output sdc_pkg::dp_stat_t      stat,
  input  wire logic              cmd,
  input  wire logic [11:0]       in_year,
  input  wire logic [3:0]        in_month,
  input  wire logic [4:0]        in_day,
  input  wire logic [16:0]       in_serial,
  output logic [16:0]            out_serial,
  output logic [11:0]            out_year,
  output logic [3:0]             out_month,
  output logic [4:0]             out_day,
  output sdc_pkg::status_t       status
);

  localparam int unsigned LAST_YEAR  = sdc_pkg::BASE_YEAR + YEAR_SPAN - 1;
  localparam int unsigned LEAPS_SPAN = LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400
                                       - sdc_pkg::LEAPS_TO_1899;
  localparam int unsigned MAX_SERIAL = YEAR_SPAN * 365 + LEAPS_SPAN + 1;
  localparam int unsigned ACC_BITS   = $clog2(MAX_SERIAL + 1);
  localparam int unsigned ACC_W      = (ACC_BITS > 17) ? ACC_BITS : 17;
  localparam int unsigned YC_BITS    = $clog2(LAST_YEAR + 2);
  localparam int unsigned YC_W       = (YC_BITS > 12) ? YC_BITS : 12;

  localparam logic [YC_W-1:0]  BASE_YEAR_V  = YC_W'(sdc_pkg::BASE_YEAR);
  localparam logic [YC_W-1:0]  LAST_YEAR_V  = YC_W'(LAST_YEAR);
  localparam logic [ACC_W-1:0] MAX_SERIAL_V = ACC_W'(MAX_SERIAL);
  localparam logic [ACC_W-1:0] FIRST_SER_V  = ACC_W'(sdc_pkg::FIRST_SERIAL);
  // 5243 / 2^17 is just above 1/25; exact floor for all 12-bit years.
  localparam logic [12:0]      RECIP25      = 13'd5243;

  logic              cmd_r;
  logic [11:0]       year_in_r;
  logic [3:0]        month_in_r;
  logic [4:0]        day_in_r;
  logic [16:0]       serial_in_r;
  logic [7:0]        q25_r;
  logic [YC_W-1:0]   yc_r;
  logic [1:0]        m4_r;
  logic [6:0]        m100_r;
  logic [8:0]        m400_r;
  logic [3:0]        mc_r;
  logic [ACC_W-1:0]  acc_r;
  sdc_pkg::status_t  status_r;

  logic [24:0]       q25_prod;
  logic [12:0]       q25_back;
  logic              div25;
  logic              leap_in;
  logic [4:0]        in_mlen;
  sdc_pkg::status_t  status_c;
  logic              leap_walk;
  logic [8:0]        year_len;
  logic [4:0]        walk_mlen;
  logic [ACC_W-1:0]  date_serial;

  assign q25_prod = 25'(in_year) * 25'(RECIP25);
  assign q25_back = 13'(q25_r) * 13'd25;
  assign div25    = (q25_back == 13'(year_in_r));
  // Divisible by 100 means by 4 and 25; by 400 means by 16 and 25.
  assign leap_in  = (year_in_r[1:0] == 2'd0) && !(div25 && year_in_r[3:0] != 4'd0);
  assign in_mlen  = sdc_pkg::days_in_month(month_in_r, leap_in);

  always_comb begin
    status_c = sdc_pkg::ST_OK;
    if (cmd_r == sdc_pkg::CMD_DATE_TO_SERIAL) begin
      if (month_in_r == 4'd0 || month_in_r > sdc_pkg::MONTH_DEC ||
          day_in_r == 5'd0 || day_in_r > in_mlen) begin
        status_c = sdc_pkg::ST_BAD_DATE;
      end else if (YC_W'(year_in_r) < BASE_YEAR_V || YC_W'(year_in_r) > LAST_YEAR_V ||
                   (YC_W'(year_in_r) == BASE_YEAR_V && month_in_r < sdc_pkg::MONTH_MAR)) begin
        status_c = sdc_pkg::ST_RANGE;
      end
    end else begin
      if (ACC_W'(serial_in_r) < FIRST_SER_V || ACC_W'(serial_in_r) > MAX_SERIAL_V) begin
        status_c = sdc_pkg::ST_RANGE;
      end
    end
  end

  assign leap_walk   = (m4_r == 2'd0) && (m100_r != 7'd0 || m400_r == 9'd0);
  assign year_len    = leap_walk ? 9'd366 : 9'd365;
  assign walk_mlen   = sdc_pkg::days_in_month(mc_r, leap_walk);
  assign date_serial = acc_r + ACC_W'(day_in_r) + ACC_W'(1);

  always_comb begin
    stat.bad = (status_c != sdc_pkg::ST_OK);
    if (cmd_r == sdc_pkg::CMD_DATE_TO_SERIAL) begin
      stat.year_done  = (yc_r == YC_W'(year_in_r));
      stat.month_done = (mc_r == month_in_r);
    end else begin
      stat.year_done  = (acc_r < ACC_W'(year_len));
      stat.month_done = (mc_r == sdc_pkg::MONTH_DEC) || (acc_r < ACC_W'(walk_mlen));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r       <= cmd;
      year_in_r   <= in_year;
      month_in_r  <= in_month;
      day_in_r    <= in_day;
      serial_in_r <= in_serial;
      q25_r       <= q25_prod[24:17];
      yc_r        <= BASE_YEAR_V;
      m4_r        <= 2'd0;
      m100_r      <= 7'(sdc_pkg::BASE_MOD100);
      m400_r      <= 9'(sdc_pkg::BASE_MOD400);
      mc_r        <= 4'd1;
      if (cmd == sdc_pkg::CMD_SERIAL_TO_DATE) begin
        acc_r <= ACC_W'(in_serial) - ACC_W'(2);
      end else begin
        acc_r <= '0;
      end
    end
    if (ctrl.check) begin
      status_r <= status_c;
    end
    if (ctrl.year_step) begin
      if (cmd_r == sdc_pkg::CMD_DATE_TO_SERIAL) begin
        acc_r <= acc_r + ACC_W'(year_len);
      end else begin
        acc_r <= acc_r - ACC_W'(year_len);
      end
      yc_r   <= yc_r + YC_W'(1);
      m4_r   <= m4_r + 2'd1;
      m100_r <= (m100_r == 7'd99) ? 7'd0 : m100_r + 7'd1;
      m400_r <= (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
    end
    if (ctrl.month_step) begin
      if (cmd_r == sdc_pkg::CMD_DATE_TO_SERIAL) begin
        acc_r <= acc_r + ACC_W'(walk_mlen);
      end else begin
        acc_r <= acc_r - ACC_W'(walk_mlen);
      end
      mc_r <= mc_r + 4'd1;
    end
    if (ctrl.finish) begin
      out_serial <= '0;
      out_year   <= '0;
      out_month  <= '0;
      out_day    <= '0;
      status     <= status_r;
      if (status_r == sdc_pkg::ST_OK) begin
        if (cmd_r == sdc_pkg::CMD_DATE_TO_SERIAL) begin
          out_serial <= date_serial[16:0];
        end else begin
          out_year  <= yc_r[11:0];
          out_month <= mc_r;
          out_day   <= acc_r[4:0] + 5'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/sdc_controller.sv
// Controller of the serial date converter: sequences check, year and month walks.
`timescale 1ns / 1ps
`default_nettype none
module sdc_controller (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire sdc_pkg::dp_stat_t  stat,
  output sdc_pkg::ctrl_cmd_t      ctrl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_YEAR,
    S_MONTH,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    ctrl          = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        ctrl.check = 1'b1;
        state_nxt  = stat.bad ? S_FINISH : S_YEAR;
      end
      S_YEAR: begin
        if (stat.year_done) begin
          state_nxt = S_MONTH;
        end else begin
          ctrl.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (stat.month_done) begin
          state_nxt = S_FINISH;
        end else begin
          ctrl.month_step = 1'b1;
        end
      end
      S_FINISH: begin
        // The result register may still hold the previous item.
        if (!out_valid_r || out_ready) begin
          ctrl.finish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### hdl/serial_date_converter.sv
// Each item is loaded, checked, walked over W < YEAR_SPAN years and M < 12 months, then written out.
// A flagged item skips both walks; no new item is accepted until the last one has been written out.
// The year walk, one year per cycle through the single accumulator, takes most of the work.
// A new item is accepted while the previous result still waits in the output register.
// Reset (synchronous, rst_n low) returns the controller to idle and clears the result valid
// flag; the datapath has no reset, as each item reloads its working registers.
`timescale 1ns / 1ps
`default_nettype none
module serial_date_converter #(
  parameter int unsigned YEAR_SPAN = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sdc_in_if.sink     in_ch,
  sdc_out_if.source  out_ch
);

  // The controller owns the handshakes and sequences the work of one item:
  // load the operands, check calendar validity and range, walk the years
  // from 1900, walk the months, then write the result register; a flagged item skips both walks.
  sdc_pkg::ctrl_cmd_t ctrl;
  sdc_pkg::dp_stat_t  stat;

  sdc_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // The datapath keeps the year counter with its remainders by 4, 100 and
  // 400 (so the leap rule needs no divider), the month counter, and one
  // accumulator that sums days for date to serial or consumes the serial
  // for serial to date. The phantom 1900-02-29 is folded in as the +1 on
  // one side and the -2 offset on the other.
  sdc_datapath #(
    .YEAR_SPAN (YEAR_SPAN)
  ) u_dp (
    .clk        (clk),
    .ctrl       (ctrl),
    .stat       (stat),
    .cmd        (in_ch.cmd),
    .in_year    (in_ch.in_year),
    .in_month   (in_ch.in_month),
    .in_day     (in_ch.in_day),
    .in_serial  (in_ch.in_serial),
    .out_serial (out_ch.out_serial),
    .out_year   (out_ch.out_year),
    .out_month  (out_ch.out_month),
    .out_day    (out_ch.out_day),
    .status     (out_ch.status)
  );

endmodule
`default_nettype wire

### test/sdc_conv_checker.sv
// Checker for the serial date converter: predicts every result and compares it field by field.
`timescale 1ns / 1ps
module sdc_conv_checker #(
  parameter int unsigned YEAR_SPAN = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  sdc_in_if           in_ch,
  sdc_out_if          out_ch,
  output int unsigned mismatches,
  output int unsigned pending
);
  import sdc_pkg::*;

  localparam int unsigned LAST_YEAR = BASE_YEAR + YEAR_SPAN - 1;
  localparam int unsigned DAYS_PER_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [16:0] serial;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    status_t     status;
  } conv_result_t;

  conv_result_t expected_results [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    if (m == MONTH_FEB && is_leap(y)) begin
      return 29;
    end
    return DAYS_PER_MONTH[(m - 1) % 12];
  endfunction

  function automatic int unsigned year_days(int unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  // Day count from 1900-01-01 up to January 1 of year y.
  function automatic int unsigned days_to_jan1(int unsigned y);
    int unsigned days;
    days = 0;
    for (int unsigned k = BASE_YEAR; k < y; k++) begin
      days += year_days(k);
    end
    return days;
  endfunction

  function automatic conv_result_t predict_conversion(logic cmd, logic [11:0] y, logic [3:0] m,
                                                      logic [4:0] d, logic [16:0] s);
    conv_result_t r;
    int unsigned  rest;
    int unsigned  yy;
    int unsigned  mm;
    r = '0;
    if (cmd == CMD_DATE_TO_SERIAL) begin
      if (m < 1 || m > MONTH_DEC || d < 1 || d > month_days(y, m)) begin
        r.status = ST_BAD_DATE;
      end else if (y < BASE_YEAR || y > LAST_YEAR || (y == BASE_YEAR && m < MONTH_MAR)) begin
        r.status = ST_RANGE;
      end else begin
        rest = days_to_jan1(y);
        for (int unsigned k = 1; k < m; k++) begin
          rest += month_days(y, k);
        end
        // Serials count from one, and the phantom leap day adds another.
        r.serial = rest + d + 1;
      end
    end else begin
      if (s < FIRST_SERIAL || s > days_to_jan1(LAST_YEAR + 1) + 1) begin
        r.status = ST_RANGE;
      end else begin
        rest = s - 2;
        yy   = BASE_YEAR;
        while (rest >= year_days(yy)) begin
          rest -= year_days(yy);
          yy++;
        end
        mm = 1;
        while (mm < MONTH_DEC && rest >= month_days(yy, mm)) begin
          rest -= month_days(yy, mm);
          mm++;
        end
        r.year  = yy;
        r.month = mm;
        r.day   = rest + 1;
      end
    end
    return r;
  endfunction

  task automatic flag_field(string field, logic [16:0] want_v, logic [16:0] got_v);
    $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    conv_result_t want;
    conv_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_conversion(in_ch.cmd, in_ch.in_year, in_ch.in_month,
                                                      in_ch.in_day, in_ch.in_serial));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_serial, out_ch.out_year, out_ch.out_month, out_ch.out_day,
                out_ch.status};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.serial !== want.serial) flag_field("out_serial", want.serial, got.serial);
          if (got.year !== want.year) flag_field("out_year", want.year, got.year);
          if (got.month !== want.month) flag_field("out_month", want.month, got.month);
          if (got.day !== want.day) flag_field("out_day", want.day, got.day);
          if (got.status !== want.status) flag_field("status", want.status, got.status);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

### test/serial_date_converter_test.sv
// Top of the serial date converter testbench: clock, reset, stimulus, back pressure and verdict.
`timescale 1ns / 1ps
module serial_date_converter_test;
  import sdc_pkg::*;

  localparam int unsigned YEAR_SPAN = 256;
  localparam int unsigned LAST_YEAR = BASE_YEAR + YEAR_SPAN - 1;
  // Serial of the last supported day, 2155-12-31, for a span of 256 years.
  localparam int unsigned TOP_SERIAL = 93503;
  // Serials up to here stay within the first few decades, which keeps the year walk short.
  localparam int unsigned NEAR_SERIAL = 13000;
  localparam int unsigned RANDOM_ITEMS = 950;

  // Pacing points for the sender, counted in items accepted so far.
  localparam int unsigned CALM_SEND_FROM = 350;
  localparam int unsigned CALM_SEND_TO   = 480;
  localparam int unsigned DRAIN_AT       = 600;
  // Pacing points for the receiver, counted in results taken so far.
  localparam int unsigned HOLD_AT        = 150;
  localparam int unsigned HOLD_CYCLES    = 1500;
  localparam int unsigned CALM_TAKE_FROM = 420;
  localparam int unsigned CALM_TAKE_TO   = 540;
  // Long enough for a full year walk and its control overhead.
  localparam int unsigned SETTLE_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned items_sent = 0;
  int unsigned results_taken = 0;

  sdc_in_if  req_ch ();
  sdc_out_if res_ch ();

  serial_date_converter #(.YEAR_SPAN(YEAR_SPAN)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  sdc_conv_checker #(.YEAR_SPAN(YEAR_SPAN)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (req_ch),
    .out_ch     (res_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  // The run is bounded no matter what the block does.
  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Results taken so far; the receiver uses this to place its long hold-off and its calm stretch.
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      results_taken++;
    end
  end

  task automatic drive_payload(logic cmd, logic [11:0] y, logic [3:0] m, logic [4:0] d,
                               logic [16:0] s);
    req_ch.cmd       <= cmd;
    req_ch.in_year   <= y;
    req_ch.in_month  <= m;
    req_ch.in_day    <= d;
    req_ch.in_serial <= s;
  endtask

  // Offers one item and returns at the falling edge after it was accepted. Every call starts at
  // a falling edge at which valid has not yet been assigned, so valid gets one update per edge.
  task automatic offer_conversion(logic cmd, logic [11:0] y, logic [3:0] m, logic [4:0] d,
                                  logic [16:0] s);
    // Once in the run the sender stops until the block has handed back everything.
    if (items_sent == DRAIN_AT) begin
      req_ch.valid <= 1'b0;
      wait (pending == 0);
      @(negedge clk);
    end
    // Random gaps, with junk on the payload so the block is seen to ignore it while valid is low.
    while (!(items_sent >= CALM_SEND_FROM && items_sent < CALM_SEND_TO) &&
           $urandom_range(99) < 33) begin
      req_ch.valid <= 1'b0;
      drive_payload($urandom, $urandom, $urandom, $urandom, $urandom);
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    drive_payload(cmd, y, m, d, s);
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    items_sent++;
    @(negedge clk);
  endtask

  // Day of month that is mostly valid; now and then one of the last three days, which may not
  // exist in the chosen month.
  function automatic logic [4:0] pick_day();
    return ($urandom_range(9) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
  endfunction

  task automatic offer_random_conversion();
    int unsigned pick;
    logic [11:0] y;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // Date with a valid month, mostly in the first few decades so the walk stays short.
      y = ($urandom_range(4) == 0) ? $urandom_range(BASE_YEAR, LAST_YEAR)
                                   : $urandom_range(BASE_YEAR, BASE_YEAR + 35);
      offer_conversion(CMD_DATE_TO_SERIAL, y, $urandom_range(1, 12), pick_day(), $urandom);
    end else if (pick < 80) begin
      offer_conversion(CMD_SERIAL_TO_DATE, $urandom, $urandom, $urandom,
                       ($urandom_range(4) == 0) ? $urandom_range(FIRST_SERIAL, TOP_SERIAL)
                                                : $urandom_range(FIRST_SERIAL, NEAR_SERIAL));
    end else if (pick < 90) begin
      // Around the edges of the supported span, in either direction.
      if ($urandom_range(1) == 0) begin
        offer_conversion(CMD_SERIAL_TO_DATE, $urandom, $urandom, $urandom,
                         ($urandom_range(1) == 0) ? $urandom_range(55, 66)
                                                  : $urandom_range(TOP_SERIAL - 6, TOP_SERIAL + 6));
      end else begin
        case ($urandom_range(3))
          0: y = BASE_YEAR - 1;
          1: y = BASE_YEAR;
          2: y = LAST_YEAR;
          default: y = LAST_YEAR + 1;
        endcase
        offer_conversion(CMD_DATE_TO_SERIAL, y, $urandom_range(1, 12), pick_day(), $urandom);
      end
    end else begin
      // Anything at all: every bit of every field, so most dates fall outside the span.
      offer_conversion($urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // Stimulus: reset, a directed opening, then the random stream, then the verdict.
  initial begin
    req_ch.valid <= 1'b0;
    drive_payload(CMD_DATE_TO_SERIAL, '0, '0, '0, '0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First and last supported days, and the days just outside them.
    offer_conversion(CMD_DATE_TO_SERIAL, 1900, 3, 1, 17'h1ffff);
    offer_conversion(CMD_DATE_TO_SERIAL, 1900, 2, 28, 0);
    offer_conversion(CMD_DATE_TO_SERIAL, 1900, 1, 1, 0);
    offer_conversion(CMD_DATE_TO_SERIAL, LAST_YEAR, 12, 31, 0);
    offer_conversion(CMD_DATE_TO_SERIAL, LAST_YEAR + 1, 1, 1, 0);
    offer_conversion(CMD_DATE_TO_SERIAL, 12'hfff, 12, 31, 0);
    // Year zero is a leap year, so its February 29 is a real date but out of range.
    offer_conversion(CMD_DATE_TO_SERIAL, 0, 2, 29, 0);
    // Bad months and bad days; the calendar check wins over the range check.
    offer_conversion(CMD_DATE_TO_SERIAL, 2000, 0, 10, 0);
    offer_conversion(CMD_DATE_TO_SERIAL, 2000, 13, 10, 0);
    offer_conversion(CMD_DATE_TO_SERIAL, 12'hfff, 15, 31, 0);
    offer_conversion(CMD_DATE_TO_SERIAL, 2000, 5, 0, 0);
    offer_conversion(CMD_DATE_TO_SERIAL, 2001, 4, 31, 0);
    offer_conversion(CMD_DATE_TO_SERIAL, 1900, 2, 29, 0);
    // Leap rule: every fourth year, except centuries not divisible by 400.
    offer_conversion(CMD_DATE_TO_SERIAL, 2000, 2, 29, 0);
    offer_conversion(CMD_DATE_TO_SERIAL, 2100, 2, 29, 0);
    offer_conversion(CMD_DATE_TO_SERIAL, 2004, 2, 29, 0);
    offer_conversion(CMD_DATE_TO_SERIAL, 1999, 1, 31, 0);
    // Serial side: below the span, the phantom day, the first and last valid serials and beyond.
    offer_conversion(CMD_SERIAL_TO_DATE, 12'hfff, 4'hf, 5'h1f, 0);
    offer_conversion(CMD_SERIAL_TO_DATE, 0, 0, 0, 1);
    offer_conversion(CMD_SERIAL_TO_DATE, 0, 0, 0, 60);
    offer_conversion(CMD_SERIAL_TO_DATE, 0, 0, 0, FIRST_SERIAL);
    offer_conversion(CMD_SERIAL_TO_DATE, 0, 0, 0, 36585);
    offer_conversion(CMD_SERIAL_TO_DATE, 0, 0, 0, TOP_SERIAL);
    offer_conversion(CMD_SERIAL_TO_DATE, 0, 0, 0, TOP_SERIAL + 1);
    offer_conversion(CMD_SERIAL_TO_DATE, 12'hfff, 4'hf, 5'h1f, 17'h1ffff);

    repeat (RANDOM_ITEMS) begin
      offer_random_conversion();
    end
    req_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off while the sender keeps offering, and a calm stretch.
  initial begin : receiver
    bit held;
    held = 1'b0;
    res_ch.ready <= 1'b0;
    @(negedge clk);
    wait (rst_n);
    forever begin
      if (!held && results_taken >= HOLD_AT) begin
        // The block fills up behind this hold-off and has to stall its input.
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res_ch.ready <= (results_taken >= CALM_TAKE_FROM && results_taken < CALM_TAKE_TO) ||
                      ($urandom_range(99) >= 33);
      @(negedge clk);
    end
  end

endmodule
